// ----- sv/vcriu_pkg.sv -----
`timescale 1ns / 1ps

package vcriu_pkg;

  localparam int unsigned NUM_REGS   = 48;
  localparam int unsigned OFF_W      = 6;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SRC_W      = 6;
  localparam int unsigned TIMER_W    = 12;

  localparam logic [OFF_W-1:0]  OFF_INIT0  = 6'h00;
  localparam logic [OFF_W-1:0]  OFF_IRQEN  = 6'h02;
  localparam logic [OFF_W-1:0]  OFF_FIRQEN = 6'h03;
  localparam logic [OFF_W-1:0]  OFF_TMSB   = 6'h04;
  localparam logic [OFF_W-1:0]  OFF_TLSB   = 6'h05;
  localparam logic [OFF_W-1:0]  OFF_MMU    = 6'h10;
  localparam logic [OFF_W-1:0]  OFF_PAL    = 6'h20;
  localparam logic [OFF_W-1:0]  OFF_LIMIT  = 6'(NUM_REGS);

  localparam logic [BYTE_W-1:0] UNMAPPED_READ = 8'h1B;
  localparam int unsigned       IRQ_CPU_BIT   = 5;
  localparam int unsigned       FIRQ_CPU_BIT  = 4;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_EVENT = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    RK_CONST = 2'd0,
    RK_MMU   = 2'd1,
    RK_PAL   = 2'd2
  } read_kind_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [OFF_W-1:0]    reg_offset;
    logic [BYTE_W-1:0]   write_byte;
    logic [SRC_W-1:0]    event_sources;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   read_byte;
    logic                irq_line;
    logic                firq_line;
    logic                timer_load;
    logic [TIMER_W-1:0]  timer_value;
  } result_t;

  // status of the interrupt unit after the word just accepted
  typedef struct packed {
    logic                irq_line;
    logic                firq_line;
    logic                timer_load;
    logic [TIMER_W-1:0]  timer_value;
    logic [SRC_W-1:0]    pend_byte;
  } irq_status_t;

endpackage

// ----- sv/vcriu_ram.sv -----
`timescale 1ns / 1ps

module vcriu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/vcriu_irq.sv -----
`timescale 1ns / 1ps

module vcriu_irq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  vcriu_pkg::item_t     item,
  output vcriu_pkg::irq_status_t status
);

  // shadow copies of the control bytes, only the bits that matter
  logic                         cpu_irq_en;
  logic                         cpu_firq_en;
  logic [vcriu_pkg::SRC_W-1:0]  irq_en;
  logic [vcriu_pkg::SRC_W-1:0]  firq_en;
  logic [3:0]                   tmsb;
  logic [7:0]                   tlsb;
  logic [vcriu_pkg::SRC_W-1:0]  irq_pend;
  logic [vcriu_pkg::SRC_W-1:0]  firq_pend;
  logic [vcriu_pkg::SRC_W-1:0]  irq_cpu;
  logic [vcriu_pkg::SRC_W-1:0]  firq_cpu;

  logic                         cpu_irq_en_next;
  logic                         cpu_firq_en_next;
  logic [vcriu_pkg::SRC_W-1:0]  irq_en_next;
  logic [vcriu_pkg::SRC_W-1:0]  firq_en_next;
  logic [3:0]                   tmsb_next;
  logic [7:0]                   tlsb_next;
  logic [vcriu_pkg::SRC_W-1:0]  irq_pend_next;
  logic [vcriu_pkg::SRC_W-1:0]  firq_pend_next;
  logic [vcriu_pkg::SRC_W-1:0]  irq_cpu_next;
  logic [vcriu_pkg::SRC_W-1:0]  firq_cpu_next;
  logic                         timer_load;
  logic [vcriu_pkg::SRC_W-1:0]  pend_byte;
  logic [vcriu_pkg::SRC_W-1:0]  keep;

  assign keep = ~item.write_byte[vcriu_pkg::SRC_W-1:0];

  always_comb begin
    cpu_irq_en_next  = cpu_irq_en;
    cpu_firq_en_next = cpu_firq_en;
    irq_en_next      = irq_en;
    firq_en_next     = firq_en;
    tmsb_next        = tmsb;
    tlsb_next        = tlsb;
    irq_pend_next    = irq_pend;
    firq_pend_next   = firq_pend;
    irq_cpu_next     = irq_cpu;
    firq_cpu_next    = firq_cpu;
    timer_load       = 1'b0;
    pend_byte        = '0;
    case (item.opcode)
      vcriu_pkg::OP_WRITE: begin
        case (item.reg_offset)
          vcriu_pkg::OFF_INIT0: begin
            cpu_irq_en_next  = item.write_byte[vcriu_pkg::IRQ_CPU_BIT];
            cpu_firq_en_next = item.write_byte[vcriu_pkg::FIRQ_CPU_BIT];
          end
          vcriu_pkg::OFF_IRQEN: begin
            irq_en_next   = item.write_byte[vcriu_pkg::SRC_W-1:0];
            irq_pend_next = irq_pend & keep;
            irq_cpu_next  = irq_cpu & keep;
          end
          vcriu_pkg::OFF_FIRQEN: begin
            firq_en_next   = item.write_byte[vcriu_pkg::SRC_W-1:0];
            firq_pend_next = firq_pend & keep;
            firq_cpu_next  = firq_cpu & keep;
          end
          vcriu_pkg::OFF_TMSB: begin
            tmsb_next  = item.write_byte[3:0];
            timer_load = 1'b1;
          end
          vcriu_pkg::OFF_TLSB: begin
            tlsb_next = item.write_byte;
          end
          default: begin
          end
        endcase
      end
      vcriu_pkg::OP_READ: begin
        if (item.reg_offset == vcriu_pkg::OFF_IRQEN) begin
          pend_byte     = irq_pend;
          irq_pend_next = '0;
          irq_cpu_next  = '0;
        end else if (item.reg_offset == vcriu_pkg::OFF_FIRQEN) begin
          pend_byte      = firq_pend;
          firq_pend_next = '0;
          firq_cpu_next  = '0;
        end
      end
      vcriu_pkg::OP_EVENT: begin
        irq_pend_next  = irq_pend | (item.event_sources & irq_en);
        firq_pend_next = firq_pend | (item.event_sources & firq_en);
        irq_cpu_next   = cpu_irq_en ? irq_pend_next : '0;
        firq_cpu_next  = cpu_firq_en ? firq_pend_next : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_irq_en  <= 1'b0;
      cpu_firq_en <= 1'b0;
      irq_en      <= '0;
      firq_en     <= '0;
      tmsb        <= '0;
      tlsb        <= '0;
      irq_pend    <= '0;
      firq_pend   <= '0;
      irq_cpu     <= '0;
      firq_cpu    <= '0;
    end else if (accept) begin
      cpu_irq_en  <= cpu_irq_en_next;
      cpu_firq_en <= cpu_firq_en_next;
      irq_en      <= irq_en_next;
      firq_en     <= firq_en_next;
      tmsb        <= tmsb_next;
      tlsb        <= tlsb_next;
      irq_pend    <= irq_pend_next;
      firq_pend   <= firq_pend_next;
      irq_cpu     <= irq_cpu_next;
      firq_cpu    <= firq_cpu_next;
    end
  end

  always_comb begin
    status.irq_line    = |irq_cpu_next;
    status.firq_line   = |firq_cpu_next;
    status.timer_load  = timer_load;
    status.timer_value = timer_load ? {tmsb_next, tlsb_next} : '0;
    status.pend_byte   = pend_byte;
  end

endmodule

// ----- sv/video_chip_register_interrupt_unit.sv -----
`timescale 1ns / 1ps
// a word accepted goes to the stage-one registers, then to the result register
// throughput: one word per cycle of reads, writes and events while result_stall is low
// the 48-byte register file is one ram, read at acceptance, its data merged with stage one
// reset clears the interrupt state, the shadow bytes and the per-entry valid bits;
// an mmu or palette entry not written since reset reads as zero, no clearing pass is needed
module video_chip_register_interrupt_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  vcriu_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_stall,
  output vcriu_pkg::result_t  result
);

  localparam int unsigned AW = $clog2(vcriu_pkg::NUM_REGS);

  // handshake and pipeline control
  logic accept;
  logic advance;
  logic s1_valid;
  logic s1_valid_next;
  logic result_valid_next;

  // stage one: everything but the stored byte is settled at acceptance
  vcriu_pkg::read_kind_e  s1_kind;
  logic [7:0]             s1_const;
  logic                   s1_hit;
  logic                   s1_irq_line;
  logic                   s1_firq_line;
  logic                   s1_timer_load;
  logic [11:0]            s1_timer_value;

  vcriu_pkg::read_kind_e  kind;
  logic [7:0]             const_byte;
  logic [7:0]             store_byte;
  logic [7:0]             read_byte;
  logic                   in_range;
  logic                   is_write;
  logic                   is_read;
  logic [AW-1:0]          addr;
  logic [vcriu_pkg::NUM_REGS-1:0] written;

  vcriu_pkg::irq_status_t status;

  // output register can take a word when empty or when its word leaves
  assign advance    = !result_valid || !result_stall;
  assign item_stall = s1_valid && !advance;
  assign accept     = item_valid && !item_stall;

  assign in_range = item.reg_offset < vcriu_pkg::OFF_LIMIT;
  assign is_write = item.opcode == vcriu_pkg::OP_WRITE;
  assign is_read  = item.opcode == vcriu_pkg::OP_READ;
  assign addr     = item.reg_offset[AW-1:0];

  // register file: written and read at acceptance, a read of the word after
  // a write already sees it since the write lands at that write's own acceptance
  vcriu_ram #(
    .WIDTH (8),
    .DEPTH (vcriu_pkg::NUM_REGS)
  ) u_store (
    .clk   (clk),
    .we    (accept && is_write && in_range),
    .waddr (addr),
    .wdata (item.write_byte),
    .re    (accept && is_read && in_range),
    .raddr (addr),
    .rdata (store_byte)
  );

  // interrupt pending sets, cpu enables and timer reload
  vcriu_irq u_irq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .status (status)
  );

  // sort the read into a fixed byte or a store lookup
  always_comb begin
    kind       = vcriu_pkg::RK_CONST;
    const_byte = '0;
    if (is_read) begin
      if (!in_range) begin
        const_byte = vcriu_pkg::UNMAPPED_READ;
      end else if (item.reg_offset >= vcriu_pkg::OFF_PAL) begin
        kind = vcriu_pkg::RK_PAL;
      end else if (item.reg_offset >= vcriu_pkg::OFF_MMU) begin
        kind = vcriu_pkg::RK_MMU;
      end else if (item.reg_offset == vcriu_pkg::OFF_IRQEN ||
                   item.reg_offset == vcriu_pkg::OFF_FIRQEN) begin
        const_byte = {2'b00, status.pend_byte};
      end else begin
        const_byte = vcriu_pkg::UNMAPPED_READ;
      end
    end
  end

  // per-entry written marks stand in for clearing the ram at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (accept && is_write && in_range) begin
      written[addr] <= 1'b1;
    end
  end

  assign s1_valid_next     = accept ? 1'b1 : (advance ? 1'b0 : s1_valid);
  assign result_valid_next = advance ? s1_valid : result_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= s1_valid_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind        <= kind;
      s1_const       <= const_byte;
      s1_hit         <= in_range && written[addr];
      s1_irq_line    <= status.irq_line;
      s1_firq_line   <= status.firq_line;
      s1_timer_load  <= status.timer_load;
      s1_timer_value <= status.timer_value;
    end
  end

  // merge the stored byte once the ram data is out
  always_comb begin
    case (s1_kind)
      vcriu_pkg::RK_MMU: read_byte = s1_hit ? store_byte : '0;
      vcriu_pkg::RK_PAL: read_byte = s1_hit ? {2'b00, store_byte[5:0]} : '0;
      default:           read_byte = s1_const;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      result.read_byte   <= read_byte;
      result.irq_line    <= s1_irq_line;
      result.firq_line   <= s1_firq_line;
      result.timer_load  <= s1_timer_load;
      result.timer_value <= s1_timer_value;
    end
  end

endmodule

// ----- sv/vcriu_checker.sv -----
`timescale 1ns / 1ps

module vcriu_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input vcriu_pkg::item_t   item,
  input logic               result_valid,
  input logic               result_stall,
  input vcriu_pkg::result_t result
);

  // a stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // no result word straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result word present after reset");

  // timer value only travels with a reload
  a_timer_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.timer_load |-> result.timer_value == '0)
    else $error("timer value without reload");

  // a reload comes from a write, which returns no read data
  a_load_no_read: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.timer_load |-> result.read_byte == '0)
    else $error("read data on a timer reload word");

endmodule

bind video_chip_register_interrupt_unit vcriu_checker u_vcriu_checker (.*);
